// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the oscillator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PAO_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PAO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pao_pkg.sv =====
// Types, constants and sine table function for the oscillator
`timescale 1ns / 1ps

package pao_pkg;

  localparam int MAG_W = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN = 2'd2;

  localparam logic [MAG_W-1:0] MAG_ONE = 17'd32768;
  localparam logic [14:0] SCALE = 15'd32000;

  localparam longint unsigned SC1 = 64'd1686629713;
  localparam longint unsigned SC3 = 64'd693598668;
  localparam longint unsigned SC5 = 64'd85569306;
  localparam longint unsigned SC7 = 64'd5026995;
  localparam longint unsigned SC9 = 64'd172272;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2
  } wave_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             last;
  } pao_item_t;

  // quarter-wave sine entry j of 2^table_bits steps, 0..32768
  function automatic logic [MAG_W-1:0] quarter_sine(input longint unsigned j,
                                                    input int table_bits);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned acc;
    t = j << (30 - table_bits);
    t2 = (t * t) >> 30;
    acc = SC7 - ((t2 * SC9) >> 30);
    acc = SC5 - ((t2 * acc) >> 30);
    acc = SC3 - ((t2 * acc) >> 30);
    acc = SC1 - ((t2 * acc) >> 30);
    acc = (t * acc) >> 30;
    acc = (acc * 64'd32768 + (64'd1 << 29)) >> 30;
    return acc[MAG_W-1:0];
  endfunction

endpackage

// ===== rtl/core/phase_accumulator_oscillator_unit.sv =====
// Top level of the phase accumulator oscillator
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Numerically controlled oscillator: each accepted request is one sample tick and returns
// one signed 16-bit sample plus the copied last-of-buffer mark. A new request is taken
// every cycle while the output is not stalled; the sustained rate of one sample per cycle is
// set by the single phase adder and the one read port of the quarter-wave sine ROM. A request
// passes the ROM read register, the queue, the gain multiply, then the scale multiply into
// the output register. A two-entry queue between the front end and the scaling back end
// lets each side stall on its own. A zero phase increment gives sample 0 and holds the
// phase. Write registers only while no sample is in flight.
module phase_accumulator_oscillator_unit #(
  parameter int PHASE_BITS = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pao_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pao_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 last_in_buffer,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [15:0]                   sample,
  output logic                                 last_in_buffer_res
);

  logic [30:0]        phase_increment;
  logic [1:0]         waveform;
  logic [15:0]        gain;

  pao_pkg::pao_item_t front_item;
  logic               front_valid;
  logic               front_ready;
  pao_pkg::pao_item_t back_item;
  logic               back_valid;
  logic               back_ready;

  logic               silent;
  logic               wave_undef;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      waveform <= '0;
      gain <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pao_pkg::REG_PHASE_INCREMENT: phase_increment <= cfg_data[30:0];
        pao_pkg::REG_WAVEFORM: waveform <= cfg_data[1:0];
        pao_pkg::REG_GAIN: gain <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  pao_front #(
    .PHASE_BITS(PHASE_BITS),
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .phase_increment(phase_increment),
    .waveform(waveform),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .last_in_buffer(last_in_buffer),
    .item(front_item),
    .item_valid(front_valid),
    .item_ready(front_ready)
  );

  pao_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_item(front_item),
    .pop_valid(back_valid),
    .pop_ready(back_ready),
    .pop_item(back_item)
  );

  pao_back u_back (
    .clk(clk),
    .rst(rst),
    .gain(gain),
    .item_valid(back_valid),
    .item_ready(back_ready),
    .item(back_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample(sample),
    .last_in_buffer_res(last_in_buffer_res)
  );

  assign silent = (phase_increment == '0);
  assign wave_undef = (waveform != pao_pkg::WAVE_SINE) && (waveform != pao_pkg::WAVE_SQUARE)
    && (waveform != pao_pkg::WAVE_SAW);

  `PAO_ASSERT_IMPLY(a_silent_zero, out_valid && silent, sample == 16'sd0, "silent sample not zero")
  `PAO_ASSERT_IMPLY(a_gain_zero, out_valid && (gain == '0), sample == 16'sd0, "zero gain sample")
  `PAO_ASSERT_IMPLY(a_bad_wave_zero, out_valid && wave_undef, sample == 16'sd0, "bad wave sample")

endmodule

// ===== rtl/core/pao_front.sv =====
// Front end: phase accumulator, waveform classification and sine ROM read
`timescale 1ns / 1ps

module pao_front #(
  parameter int PHASE_BITS = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [30:0]         phase_increment,
  input  logic [1:0]          waveform,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                last_in_buffer,
  output pao_pkg::pao_item_t  item,
  output logic                item_valid,
  input  logic                item_ready
);

  localparam int QSTEPS = 1 << SINE_TABLE_BITS;
  localparam int AW = SINE_TABLE_BITS + 1;

  logic [pao_pkg::MAG_W-1:0] sine_rom [QSTEPS+1];

  for (genvar j = 0; j <= QSTEPS; j++) begin : g_rom
    assign sine_rom[j] = pao_pkg::quarter_sine(64'(j), SINE_TABLE_BITS);
  end

  logic [PHASE_BITS-1:0]      phase;
  logic [PHASE_BITS-1:0]      phase_next;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k;
  logic [15:0]                top16;
  logic [AW-1:0]              rom_addr;
  logic                       accept;
  logic                       silent;

  logic                       f1_valid;
  logic                       f1_sine;
  logic                       f1_neg;
  logic [pao_pkg::MAG_W-1:0]  f1_mag;
  logic                       f1_last;
  logic [pao_pkg::MAG_W-1:0]  rom_q;

  logic                       sine_next;
  logic                       neg_next;
  logic [pao_pkg::MAG_W-1:0]  mag_next;

  assign quad = phase[PHASE_BITS-1 -: 2];
  assign k = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
  assign top16 = phase[PHASE_BITS-1 -: 16];
  assign rom_addr = quad[0] ? (AW'(QSTEPS) - {1'b0, k}) : {1'b0, k};
  assign silent = (phase_increment == '0);

  assign in_ready = !f1_valid || item_ready;
  assign accept = in_valid && in_ready;
  assign phase_next = phase + PHASE_BITS'(phase_increment);

  always_comb begin
    sine_next = 1'b0;
    neg_next = 1'b0;
    mag_next = '0;
    case (waveform)
      pao_pkg::WAVE_SINE: begin
        sine_next = 1'b1;
        neg_next = quad[1];
      end
      pao_pkg::WAVE_SQUARE: begin
        mag_next = pao_pkg::MAG_ONE;
        neg_next = phase[PHASE_BITS-1];
      end
      pao_pkg::WAVE_SAW: begin
        if (top16[15]) begin
          mag_next = {2'b00, top16[14:0]};
        end else begin
          mag_next = pao_pkg::MAG_ONE - {1'b0, top16};
          neg_next = 1'b1;
        end
      end
      default: begin
        mag_next = '0;
      end
    endcase
    if (silent) begin
      sine_next = 1'b0;
      mag_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      f1_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        f1_valid <= 1'b1;
      end else if (item_ready) begin
        f1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_sine <= sine_next;
      f1_neg <= neg_next;
      f1_mag <= mag_next;
      f1_last <= last_in_buffer;
      rom_q <= sine_rom[rom_addr];
    end
  end

  assign item_valid = f1_valid;
  assign item.mag = f1_sine ? rom_q : f1_mag;
  assign item.neg = f1_neg;
  assign item.last = f1_last;

endmodule

// ===== rtl/core/pao_queue.sv =====
// Two-entry queue between front and back ends
`timescale 1ns / 1ps

module pao_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  pao_pkg::pao_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pao_pkg::pao_item_t pop_item
);

  pao_pkg::pao_item_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/pao_back.sv =====
// Back end: gain and output scaling, saturation and output register
`timescale 1ns / 1ps

module pao_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        gain,
  input  logic               item_valid,
  output logic               item_ready,
  input  pao_pkg::pao_item_t item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               last_in_buffer_res
);

  logic        b1_valid;
  logic [32:0] b1_prod;
  logic        b1_neg;
  logic        b1_last;
  logic        b1_load;
  logic        b2_valid;
  logic        b2_load;
  logic [47:0] scaled;
  logic [17:0] q;
  logic [15:0] sample_next;

  assign b2_load = b1_valid && (!b2_valid || out_ready);
  assign b1_load = item_valid && (!b1_valid || b2_load);
  assign item_ready = !b1_valid || b2_load;

  assign scaled = 48'(b1_prod) * 48'(pao_pkg::SCALE);
  assign q = scaled[47:30];

  always_comb begin
    if (b1_neg) begin
      sample_next = (q >= 18'd32768) ? 16'h8000 : 16'(-q[15:0]);
    end else begin
      sample_next = (q > 18'd32767) ? 16'h7fff : q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      if (b1_load) begin
        b1_valid <= 1'b1;
      end else if (b2_load) begin
        b1_valid <= 1'b0;
      end
      if (b2_load) begin
        b2_valid <= 1'b1;
      end else if (out_ready) begin
        b2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b1_load) begin
      b1_prod <= 33'(item.mag) * 33'(gain);
      b1_neg <= item.neg;
      b1_last <= item.last;
    end
    if (b2_load) begin
      sample <= sample_next;
      last_in_buffer_res <= b1_last;
    end
  end

  assign out_valid = b2_valid;

endmodule
